// ===== design/pacc_pkg.sv =====
// Shared types, constants and lookup functions of the packed archive chain checker.
package pacc_pkg;

  localparam int unsigned HDR_LEN = 41;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BANNER    = 4'd1;
  localparam logic [3:0] ST_MARK      = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_METHOD    = 4'd4;
  localparam logic [3:0] ST_RESERVED  = 4'd5;
  localparam logic [3:0] ST_LENGTH    = 4'd6;
  localparam logic [3:0] ST_SHORT     = 4'd7;
  localparam logic [3:0] ST_ZERO_PLN  = 4'd8;
  localparam logic [3:0] ST_RATIO     = 4'd9;
  localparam logic [3:0] ST_NAME      = 4'd10;
  localparam logic [3:0] ST_COUNT     = 4'd11;
  localparam logic [3:0] ST_TRUNCATED = 4'd12;

  localparam logic [1:0] REG_MAX_LENGTH  = 2'd0;
  localparam logic [1:0] REG_MAX_RATIO   = 2'd1;
  localparam logic [1:0] REG_RATIO_SLACK = 2'd2;
  localparam logic [1:0] REG_MAX_MEMBERS = 2'd3;

  localparam logic [7:0] EOF_MARK    = 8'h1a;
  localparam logic [7:0] VERSION_ID  = 8'h03;
  localparam logic [7:0] METHOD_ID   = 8'h00;
  localparam logic [7:0] CHAR_LOW    = 8'h20;
  localparam logic [7:0] CHAR_HIGH   = 8'h7e;

  typedef enum logic {PH_HEADER, PH_PAYLOAD} phase_e;

  // One result waiting in the queue; the timestamp is still in DOS form.
  typedef struct packed {
    logic        kind;
    logic [16:0] idx;
    logic [31:0] hoff;
    logic [28:0] packed_sz;
    logic [28:0] plain_sz;
    logic [3:0]  nlen;
    logic [31:0] alen;
    logic [3:0]  status;
    logic        last;
    logic [15:0] date;
    logic [15:0] tod;
  } res_t;

  // Up to two results written by one beat.
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } wr_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] idx;
    logic [31:0] hoff;
    logic [28:0] packed_sz;
    logic [28:0] plain_sz;
    logic [32:0] unix;
    logic [3:0]  nlen;
    logic [31:0] alen;
    logic [3:0]  status;
    logic        last;
  } out_t;

  function automatic logic [7:0] banner_byte(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = 8'h20;
      4'd1:    c = 8'h45;
      4'd2:    c = 8'h44;
      4'd3:    c = 8'h43;
      4'd4:    c = 8'h20;
      4'd5:    c = 8'h50;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h63;
      4'd8:    c = 8'h6b;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h64;
      4'd11:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Days before the first of the given month (1..12), non-leap year.
  function automatic logic [8:0] month_days(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/pacc_front.sv =====
// Front end: configuration registers and the per-beat header walker.
module pacc_front import pacc_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LENGTH_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [28:0] cfg_data_i,
  output wr_t         wr_o
);

  localparam logic [32:0] LIM_CAP = 33'd1 << LENGTH_BITS;

  logic [28:0] max_length_q;
  logic [10:0] max_ratio_q;
  logic [15:0] ratio_slack_q;
  logic [16:0] max_members_q;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, mstart_q, mstart_d;
  logic [31:0]            mlen_q, mlen_d, plen_q, plen_d;
  logic [15:0]            time_q, time_d, date_q, date_d;
  logic [3:0]             ncount_q, ncount_d;
  logic                   nended_q, nended_d;
  logic [16:0]            mcount_q, mcount_d;
  logic [3:0]             err_q, err_d;
  logic [5:0]             bad_q, bad_d;  // banner, mark, version, method, reserved, name
  logic [42:0]            prod_q, prod_d;

  logic [5:0]  hpos;
  logic [3:0]  st;
  logic [32:0] lim;
  logic [43:0] ratio_lim;
  logic        rec_v, ver_v;
  logic [3:0]  ver_st;
  res_t        rec, ver;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q  <= 29'h1000_0000;
      max_ratio_q   <= 11'd64;
      ratio_slack_q <= 16'd4096;
      max_members_q <= 17'h1_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_LENGTH:  max_length_q  <= cfg_data_i;
        REG_MAX_RATIO:   max_ratio_q   <= cfg_data_i[10:0];
        REG_RATIO_SLACK: ratio_slack_q <= cfg_data_i[15:0];
        REG_MAX_MEMBERS: max_members_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // A verdict returns the walker to its reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      off_q    <= '0;
      mstart_q <= '0;
      mlen_q   <= '0;
      plen_q   <= '0;
      time_q   <= '0;
      date_q   <= '0;
      ncount_q <= '0;
      nended_q <= 1'b0;
      mcount_q <= '0;
      err_q    <= '0;
      bad_q    <= '0;
    end else if (ver_v) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      off_q    <= '0;
      mstart_q <= '0;
      mlen_q   <= '0;
      plen_q   <= '0;
      time_q   <= '0;
      date_q   <= '0;
      ncount_q <= '0;
      nended_q <= 1'b0;
      mcount_q <= '0;
      err_q    <= '0;
      bad_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      off_q    <= off_d;
      mstart_q <= mstart_d;
      mlen_q   <= mlen_d;
      plen_q   <= plen_d;
      time_q   <= time_d;
      date_q   <= date_d;
      ncount_q <= ncount_d;
      nended_q <= nended_d;
      mcount_q <= mcount_d;
      err_q    <= err_d;
      bad_q    <= bad_d;
    end
  end

  // Ratio product, formed at header byte 35 once the member length is complete.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign hpos = pos_q[5:0];
  assign lim  = ({4'd0, max_length_q} > LIM_CAP) ? LIM_CAP : {4'd0, max_length_q};
  assign ratio_lim = {1'b0, prod_q} + {28'd0, ratio_slack_q};

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    off_d    = off_q;
    mstart_d = mstart_q;
    mlen_d   = mlen_q;
    plen_d   = plen_q;
    time_d   = time_q;
    date_d   = date_q;
    ncount_d = ncount_q;
    nended_d = nended_q;
    mcount_d = mcount_q;
    err_d    = err_q;
    bad_d    = bad_q;
    prod_d   = prod_q;
    rec_v    = 1'b0;
    ver_v    = 1'b0;
    st       = ST_OK;
    ver_st   = ST_OK;
    if (accept_i) begin
      off_d = off_q + 1'b1;
      if (err_q == ST_OK) begin
        unique case (phase_q)
          PH_HEADER: begin
            if (hpos == 6'd0 && mcount_q >= max_members_q) begin
              err_d = ST_COUNT;
            end else begin
              if (hpos == 6'd0) begin
                mstart_d = off_q;
                mlen_d   = '0;
                plen_d   = '0;
                time_d   = '0;
                date_d   = '0;
                ncount_d = '0;
                nended_d = 1'b0;
                bad_d    = '0;
              end
              if (hpos < 6'd12) begin
                if (data_byte_i != banner_byte(hpos[3:0])) bad_d[0] = 1'b1;
              end else if (hpos < 6'd24) begin
                if (nended_d) begin
                  if (data_byte_i != 8'd0) bad_d[5] = 1'b1;
                end else if (data_byte_i == 8'd0) begin
                  nended_d = 1'b1;
                end else begin
                  if (data_byte_i < CHAR_LOW || data_byte_i > CHAR_HIGH) bad_d[5] = 1'b1;
                  ncount_d = ncount_d + 1'b1;
                end
              end else begin
                case (hpos)
                  6'd24: if (data_byte_i != EOF_MARK) bad_d[1] = 1'b1;
                  6'd25: if (data_byte_i != VERSION_ID) bad_d[2] = 1'b1;
                  6'd26: if (data_byte_i != METHOD_ID) bad_d[3] = 1'b1;
                  6'd27: plen_d[7:0]   = data_byte_i;
                  6'd28: plen_d[15:8]  = data_byte_i;
                  6'd29: plen_d[23:16] = data_byte_i;
                  6'd30: plen_d[31:24] = data_byte_i;
                  6'd31: mlen_d[7:0]   = data_byte_i;
                  6'd32: mlen_d[15:8]  = data_byte_i;
                  6'd33: mlen_d[23:16] = data_byte_i;
                  6'd34: mlen_d[31:24] = data_byte_i;
                  6'd35, 6'd36: if (data_byte_i != 8'd0) bad_d[4] = 1'b1;
                  6'd37: time_d[7:0]   = data_byte_i;
                  6'd38: time_d[15:8]  = data_byte_i;
                  6'd39: date_d[7:0]   = data_byte_i;
                  default: date_d[15:8] = data_byte_i;
                endcase
              end
              if (hpos == 6'd35) begin
                prod_d = 43'(mlen_q - 32'd41) * 43'(max_ratio_q);
              end
              if (hpos == 6'(HDR_LEN - 1)) begin
                if (bad_d[0])                                st = ST_BANNER;
                else if (bad_d[1])                           st = ST_MARK;
                else if (bad_d[2])                           st = ST_VERSION;
                else if (bad_d[3])                           st = ST_METHOD;
                else if (bad_d[4])                           st = ST_RESERVED;
                else if ({1'b0, mlen_d} > lim)               st = ST_LENGTH;
                else if (mlen_d <= 32'(HDR_LEN))             st = ST_SHORT;
                else if ({1'b0, plen_d} > lim)               st = ST_LENGTH;
                else if (plen_d == 32'd0)                    st = ST_ZERO_PLN;
                else if ({12'd0, plen_d} > ratio_lim)        st = ST_RATIO;
                else if (bad_d[5] || ncount_d == 4'd0)       st = ST_NAME;
                pos_d = '0;
                if (st != ST_OK) begin
                  err_d = st;
                end else begin
                  rec_v    = 1'b1;
                  mcount_d = mcount_q + 1'b1;
                  phase_d  = PH_PAYLOAD;
                  pos_d    = LENGTH_BITS'(mlen_d - 32'(HDR_LEN));
                end
              end else begin
                pos_d = LENGTH_BITS'(hpos + 6'd1);
              end
            end
          end
          PH_PAYLOAD: begin
            pos_d = pos_q - 1'b1;
            if (pos_q == LENGTH_BITS'(1)) phase_d = PH_HEADER;
          end
          default: ;
        endcase
      end
      if (end_of_file_i) begin
        ver_v = 1'b1;
        if (err_d != ST_OK) ver_st = err_d;
        else if (phase_d == PH_HEADER && pos_d == '0 && mcount_d != '0) ver_st = ST_OK;
        else ver_st = ST_TRUNCATED;
      end
    end
  end

  always_comb begin
    rec.kind      = 1'b0;
    rec.idx       = mcount_q;
    rec.hoff      = 32'(mstart_d);
    rec.packed_sz = 29'(mlen_d - 32'(HDR_LEN));
    rec.plain_sz  = plen_d[28:0];
    rec.nlen      = ncount_d;
    rec.alen      = 32'(off_d);
    rec.status    = ST_OK;
    rec.last      = !ver_v;
    rec.date      = date_d;
    rec.tod       = time_d;

    ver.kind      = 1'b1;
    ver.idx       = mcount_d;
    ver.hoff      = 32'(mstart_d);
    ver.packed_sz = '0;
    ver.plain_sz  = '0;
    ver.nlen      = '0;
    ver.alen      = 32'(off_d);
    ver.status    = ver_st;
    ver.last      = 1'b1;
    ver.date      = '0;  // month zero: timestamp comes out as zero
    ver.tod       = '0;

    wr_o.n = 2'd0;
    wr_o.a = rec;
    wr_o.b = ver;
    if (rec_v && ver_v) wr_o.n = 2'd2;
    else if (rec_v) wr_o.n = 2'd1;
    else if (ver_v) begin
      wr_o.n = 2'd1;
      wr_o.a = ver;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> pos_q != '0)
    else $error("payload phase with nothing left to skip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK |-> phase_q == PH_HEADER)
    else $error("error latched outside header phase");

endmodule

// ===== design/pacc_fifo.sv =====
// Four-entry result queue between front and back; takes up to two writes a beat.
module pacc_fifo import pacc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  wr_t  wr_i,
  input  logic rd_i,
  output res_t rd_data_o,
  output logic rd_valid_o,
  output logic room_o
);

  res_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] count_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.n != 2'd0) mem_q[wptr_q] <= wr_i.a;
    if (wr_i.n == 2'd2) mem_q[wptr_q + 2'd1] <= wr_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + wr_i.n;
      rptr_q  <= rptr_q + 2'(rd_i);
      count_q <= count_q + 3'(wr_i.n) - 3'(rd_i);
    end
  end

  assign rd_data_o  = mem_q[rptr_q];
  assign rd_valid_o = count_q != 3'd0;
  assign room_o     = count_q <= 3'd2;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 3'd4)
    else $error("queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i.n == 2'd2 |-> count_q <= 3'd2)
    else $error("double write without room");

endmodule

// ===== design/pacc_back.sv =====
// Back end: DOS timestamp conversion over two stages, the second of which is the result register.
module pacc_back import pacc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  res_t head_i,
  input  logic head_valid_i,
  output logic head_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output out_t res_o
);

  res_t        s1_q;
  logic        s1_v_q, s2_v_q;
  logic [16:0] days_q;
  logic [16:0] secs_q;
  logic        ok_q;
  out_t        s2_q;
  logic        s1_ld, s2_ld;

  assign s2_ld      = !s2_v_q || pop_i;
  assign s1_ld      = !s1_v_q || s2_ld;
  assign head_pop_o = head_valid_i && s1_ld;

  logic [6:0]  yo;
  logic [3:0]  mo;
  logic [4:0]  dy, hr;
  logic [5:0]  mi, sc;
  logic        leap, ok;
  logic [16:0] days, secs;

  always_comb begin
    yo   = head_i.date[15:9];
    mo   = head_i.date[8:5];
    dy   = head_i.date[4:0];
    hr   = head_i.tod[15:11];
    mi   = head_i.tod[10:5];
    sc   = {head_i.tod[4:0], 1'b0};
    leap = (yo[1:0] == 2'd0) && (yo != 7'd120);  // 2100 is not a leap year
    ok   = mo >= 4'd1 && mo <= 4'd12 && dy != 5'd0 && hr <= 5'd23 && mi <= 6'd59 &&
           sc <= 6'd59;
    // 3652 days from 1970 to 1980, then whole years and their leap days since 1980
    days = 17'd3652 + 17'(yo) * 17'd365 + 17'((8'(yo) + 8'd3) >> 2)
         - 17'(yo > 7'd120) + 17'(month_days(mo)) + 17'(mo > 4'd2 && leap)
         + 17'(dy) - 17'd1;
    secs = 17'(hr) * 17'd3600 + 17'(mi) * 17'd60 + 17'(sc);
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_q   <= head_i;
      days_q <= days;
      secs_q <= secs;
      ok_q   <= ok;
    end
    if (s2_ld) begin
      s2_q.kind      <= s1_q.kind;
      s2_q.idx       <= s1_q.idx;
      s2_q.hoff      <= s1_q.hoff;
      s2_q.packed_sz <= s1_q.packed_sz;
      s2_q.plain_sz  <= s1_q.plain_sz;
      s2_q.unix      <= ok_q ? 33'(days_q) * 33'd86400 + 33'(secs_q) : 33'd0;
      s2_q.nlen      <= s1_q.nlen;
      s2_q.alen      <= s1_q.alen;
      s2_q.status    <= s1_q.status;
      s2_q.last      <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ld) s1_v_q <= head_valid_i;
      if (s2_ld) s2_v_q <= s1_v_q;
    end
  end

  assign empty_o = !s2_v_q;
  assign res_o   = s2_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) s2_v_q && !pop_i |=> s2_v_q)
    else $error("result dropped before pop");

endmodule

// ===== design/packed_archive_chain_checker_unit.sv =====
// Top level of the packed archive chain checker: front walker, result queue, back end.
// Takes one byte per cycle while full is low; full rises when fewer than two queue
// slots are free. A result passes from the queue, written at the edge that takes its byte,
// through the conversion stage to the result register; one result a cycle while pop is high.
// A byte that completes a header and ends the stream gives two results on two pops.
// Reset is asynchronous: walker state and queue clear at once, the configuration
// registers return to their defaults; no clearing pass.
module packed_archive_chain_checker_unit import pacc_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LENGTH_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic        record_kind_o,
  output logic [16:0] member_index_o,
  output logic [31:0] header_offset_o,
  output logic [28:0] packed_size_o,
  output logic [28:0] plain_size_o,
  output logic [32:0] unix_time_o,
  output logic [3:0]  name_length_o,
  output logic [31:0] archive_length_o,
  output logic [3:0]  status_o,
  output logic        last_result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [28:0] cfg_data_i
);

  wr_t  wr;
  res_t head;
  logic head_valid, head_pop, room;
  out_t res;

  assign full        = !room;
  assign cfg_ready_o = 1'b1;

  pacc_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (push && room),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .wr_o         (wr)
  );

  pacc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_i      (head_pop),
    .rd_data_o (head),
    .rd_valid_o(head_valid),
    .room_o    (room)
  );

  pacc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .head_pop_o  (head_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign record_kind_o    = res.kind;
  assign member_index_o   = res.idx;
  assign header_offset_o  = res.hoff;
  assign packed_size_o    = res.packed_sz;
  assign plain_size_o     = res.plain_sz;
  assign unix_time_o      = res.unix;
  assign name_length_o    = res.nlen;
  assign archive_length_o = res.alen;
  assign status_o         = res.status;
  assign last_result_o    = res.last;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the packed archive chain checker: member chains, verdicts, limits.
module tb;
  import pacc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LEN_CAP    = 64'd1 << 28;
  localparam int unsigned     CYCLE_CAP  = 600000;
  localparam int unsigned     DRAIN_WAIT = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_file_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        record_kind_o;
  logic [16:0] member_index_o;
  logic [31:0] header_offset_o;
  logic [28:0] packed_size_o;
  logic [28:0] plain_size_o;
  logic [32:0] unix_time_o;
  logic [3:0]  name_length_o;
  logic [31:0] archive_length_o;
  logic [3:0]  status_o;
  logic        last_result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [28:0] cfg_data_i = '0;

  packed_archive_chain_checker_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  // configuration copy
  longint unsigned lim_length = LEN_CAP, lim_ratio = 64, lim_slack = 4096,
                   lim_members = 65536;

  // walker copy
  bit              in_payload;
  longint unsigned hdr_pos, mem_start, mem_len, pln_len, mem_count;
  bit [31:0]       byte_count;
  bit [15:0]       dos_tod, dos_day;
  int unsigned     name_chars;
  bit              name_done;
  logic [3:0]      first_err;
  bit [5:0]        hdr_faults; // banner, mark, version, method, reserved, name

  out_t            pending_results[$];
  int unsigned     mismatches, bytes_sent, results_seen, cycles;
  bit              sender_gaps = 1'b1, receiver_stalls = 1'b1;

  logic [7:0]      hdr [41];
  logic [7:0]      arc [$];

  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic logic [32:0] dos_to_unix(bit [15:0] dt, bit [15:0] tm);
    int unsigned yr, mo, dy, hh, mi, ss;
    longint unsigned days;
    yr = 1980 + dt[15:9];
    mo = dt[8:5];
    dy = dt[4:0];
    hh = tm[15:11];
    mi = tm[10:5];
    ss = tm[4:0] * 2;
    days = 0;
    if (mo < 1 || mo > 12 || dy < 1 || hh > 23 || mi > 59 || ss > 59) return '0;
    for (int unsigned y = 1970; y < yr; y++) days += leap_year(y) ? 366 : 365;
    days += month_days(mo[3:0]);
    if (mo > 2 && leap_year(yr)) days += 1;
    days += dy - 1;
    return 33'(days * 86400 + hh * 3600 + mi * 60 + ss);
  endfunction

  function automatic logic [3:0] header_verdict();
    longint unsigned lim;
    lim = (lim_length > LEN_CAP) ? LEN_CAP : lim_length;
    if (hdr_faults[0]) return ST_BANNER;
    if (hdr_faults[1]) return ST_MARK;
    if (hdr_faults[2]) return ST_VERSION;
    if (hdr_faults[3]) return ST_METHOD;
    if (hdr_faults[4]) return ST_RESERVED;
    if (mem_len > lim) return ST_LENGTH;
    if (mem_len <= HDR_LEN) return ST_SHORT;
    if (pln_len > lim) return ST_LENGTH;
    if (pln_len < 1) return ST_ZERO_PLN;
    if (pln_len > (mem_len - HDR_LEN) * lim_ratio + lim_slack) return ST_RATIO;
    if (hdr_faults[5] || name_chars == 0) return ST_NAME;
    return ST_OK;
  endfunction

  function automatic void clear_walker();
    in_payload = 0; hdr_pos = 0; byte_count = 0; mem_start = 0; mem_len = 0;
    pln_len = 0; dos_tod = 0; dos_day = 0; name_chars = 0; name_done = 0;
    mem_count = 0; first_err = ST_OK; hdr_faults = 0;
  endfunction

  // Works out the results one accepted beat causes.
  function automatic void walk_byte(logic [7:0] b, logic eof);
    out_t r, fresh[$];
    longint unsigned start;
    logic [3:0] st;
    int unsigned p;
    start = byte_count;
    byte_count = byte_count + 1;
    if (first_err == ST_OK) begin
      if (in_payload) begin
        if (hdr_pos > 0) hdr_pos--;
        if (hdr_pos == 0) in_payload = 0;
      end else begin
        p = hdr_pos;
        if (p == 0 && mem_count >= lim_members) begin
          first_err = ST_COUNT;
        end else begin
          if (p == 0) begin
            mem_start = start; mem_len = 0; pln_len = 0; dos_tod = 0; dos_day = 0;
            name_chars = 0; name_done = 0; hdr_faults = 0;
          end
          if (p < 12) begin
            if (b != banner_byte(p[3:0])) hdr_faults[0] = 1;
          end else if (p < 24) begin
            if (name_done) begin
              if (b != 0) hdr_faults[5] = 1;
            end else if (b == 0) begin
              name_done = 1;
            end else begin
              if (b < CHAR_LOW || b > CHAR_HIGH) hdr_faults[5] = 1;
              name_chars++;
            end
          end else if (p == 24) begin
            if (b != EOF_MARK) hdr_faults[1] = 1;
          end else if (p == 25) begin
            if (b != VERSION_ID) hdr_faults[2] = 1;
          end else if (p == 26) begin
            if (b != METHOD_ID) hdr_faults[3] = 1;
          end else if (p < 31) begin
            pln_len |= longint'(b) << (8 * (p - 27));
          end else if (p < 35) begin
            mem_len |= longint'(b) << (8 * (p - 31));
          end else if (p < 37) begin
            if (b != 0) hdr_faults[4] = 1;
          end else if (p < 39) begin
            dos_tod |= 16'(b) << (8 * (p - 37));
          end else begin
            dos_day |= 16'(b) << (8 * (p - 39));
          end
          hdr_pos = p + 1;
          if (hdr_pos == HDR_LEN) begin
            st = header_verdict();
            hdr_pos = 0;
            if (st != ST_OK) begin
              first_err = st;
            end else begin
              r = '0;
              r.idx = mem_count[16:0];
              r.hoff = mem_start[31:0];
              r.packed_sz = 29'(mem_len - HDR_LEN);
              r.plain_sz = pln_len[28:0];
              r.unix = dos_to_unix(dos_day, dos_tod);
              r.nlen = name_chars[3:0];
              r.alen = byte_count;
              r.status = ST_OK;
              fresh.push_back(r);
              mem_count++;
              in_payload = 1;
              hdr_pos = mem_len - HDR_LEN;
            end
          end
        end
      end
    end
    if (eof) begin
      st = first_err;
      if (st == ST_OK)
        st = (!in_payload && hdr_pos == 0 && mem_count > 0) ? ST_OK : ST_TRUNCATED;
      r = '0;
      r.kind = 1'b1;
      r.idx = mem_count[16:0];
      r.hoff = mem_start[31:0];
      r.alen = byte_count;
      r.status = st;
      fresh.push_back(r);
      clear_walker();
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) pending_results.push_back(fresh[i]);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(logic [7:0] b, logic eof);
    int unsigned g;
    g = sender_gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (full);
    walk_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_archive();
    foreach (arc[i]) send_byte(arc[i], i == arc.size() - 1);
    arc.delete();
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, longint unsigned val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[28:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MAX_LENGTH:  lim_length = val & 29'h1fffffff;
      REG_MAX_RATIO:   lim_ratio = val & 11'h7ff;
      REG_RATIO_SLACK: lim_slack = val & 16'hffff;
      default:         lim_members = val & 17'h1ffff;
    endcase
  endtask

  task automatic set_limits(longint unsigned len, longint unsigned ratio,
                            longint unsigned slack, longint unsigned members);
    write_reg(REG_MAX_LENGTH, len);
    write_reg(REG_MAX_RATIO, ratio);
    write_reg(REG_RATIO_SLACK, slack);
    write_reg(REG_MAX_MEMBERS, members);
  endtask

  task automatic fill_header(longint unsigned plain, longint unsigned mlen, int unsigned nlen);
    for (int i = 0; i < 12; i++) hdr[i] = banner_byte(i[3:0]);
    for (int i = 0; i < 12; i++) hdr[12 + i] = (i < nlen) ? 8'($urandom_range(32, 126)) : 8'h00;
    hdr[24] = EOF_MARK;
    hdr[25] = VERSION_ID;
    hdr[26] = METHOD_ID;
    for (int i = 0; i < 4; i++) hdr[27 + i] = 8'(plain >> (8 * i));
    for (int i = 0; i < 4; i++) hdr[31 + i] = 8'(mlen >> (8 * i));
    hdr[35] = 8'h00;
    hdr[36] = 8'h00;
    for (int i = 37; i < 41; i++) hdr[i] = 8'($urandom);
  endtask

  task automatic add_header(int unsigned n);
    for (int unsigned i = 0; i < n; i++) arc.push_back(hdr[i]);
  endtask

  task automatic add_payload(int unsigned n);
    repeat (n) arc.push_back(8'($urandom));
  endtask

  // Valid member that fits the current limits; small payloads mostly.
  task automatic add_good_member();
    longint unsigned lim, pk, pmax, pl;
    lim = (lim_length > LEN_CAP) ? LEN_CAP : lim_length;
    pk = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
    if (pk > lim - HDR_LEN) pk = lim - HDR_LEN;
    pmax = pk * lim_ratio + lim_slack;
    if (pmax > lim) pmax = lim;
    pl = ($urandom_range(0, 4) == 0) ? pmax : $urandom_range(1, 32'(pmax));
    fill_header(pl, pk + HDR_LEN, $urandom_range(0, 9) == 0 ? 12 : $urandom_range(1, 12));
    add_header(HDR_LEN);
    add_payload(pk);
  endtask

  task automatic error_case(logic [3:0] which);
    fill_header(100, HDR_LEN + 10, 8);
    case (which)
      ST_BANNER:   hdr[5] = hdr[5] ^ 8'h01;
      ST_MARK:     hdr[24] = 8'h00;
      ST_VERSION:  hdr[25] = 8'h04;
      ST_METHOD:   hdr[26] = 8'hff;
      ST_RESERVED: hdr[36] = 8'h80;
      ST_LENGTH:   {hdr[34], hdr[33], hdr[32], hdr[31]} = 32'hffffffff;
      ST_SHORT:    {hdr[34], hdr[33], hdr[32], hdr[31]} = HDR_LEN;
      ST_ZERO_PLN: {hdr[30], hdr[29], hdr[28], hdr[27]} = 32'd0;
      ST_RATIO:    {hdr[30], hdr[29], hdr[28], hdr[27]} = 32'd10 * 64 + 4096 + 1;
      default:     hdr[12] = 8'h1f;
    endcase
    add_header(HDR_LEN);
    add_payload(3);
    send_archive();
  endtask

  task automatic test_header_checks();
    // good single member, both banner-side errors and all field errors
    fill_header(100, HDR_LEN + 10, 8);
    add_header(HDR_LEN);
    add_payload(10);
    send_archive();
    error_case(ST_BANNER);
    error_case(ST_MARK);
    error_case(ST_VERSION);
    error_case(ST_METHOD);
    error_case(ST_RESERVED);
    error_case(ST_LENGTH);
    error_case(ST_SHORT);
    error_case(ST_ZERO_PLN);
    error_case(ST_RATIO);
    error_case(ST_NAME);
    // plaintext above limit
    fill_header(32'hffffffff, HDR_LEN + 2, 4);
    add_header(HDR_LEN);
    send_archive();
  endtask

  task automatic test_name_field();
    fill_header(5, HDR_LEN + 1, 0); // empty name
    add_header(HDR_LEN);
    add_payload(1);
    send_archive();
    fill_header(5, HDR_LEN + 1, 3); // text after the NUL
    hdr[20] = 8'h41;
    add_header(HDR_LEN);
    add_payload(1);
    send_archive();
    fill_header(5, HDR_LEN + 1, 12); // full width, top printable char
    hdr[23] = CHAR_HIGH;
    hdr[12] = CHAR_LOW;
    {hdr[40], hdr[39], hdr[38], hdr[37]} = 32'hffff_ffff;
    add_header(HDR_LEN);
    add_payload(1);
    fill_header(5, HDR_LEN + 1, 2);
    hdr[13] = 8'h7f;
    add_header(HDR_LEN);
    add_payload(1);
    send_archive();
  endtask

  task automatic test_truncation();
    send_byte(8'hff, 1'b1); // stream of one byte
    fill_header(7, HDR_LEN + 4, 5);
    add_header(20);
    send_archive();
    add_header(HDR_LEN); // header completes on the last byte: record then verdict
    send_archive();
    add_header(HDR_LEN);
    add_payload(2);
    send_archive();
    add_header(HDR_LEN);
    add_payload(4);
    add_payload(1); // one stray byte after an exact fit
    send_archive();
  endtask

  task automatic test_member_count();
    set_limits(HDR_LEN + 1, 1, 0, 1);
    fill_header(1, HDR_LEN + 1, 1);
    add_header(HDR_LEN);
    add_payload(1);
    add_header(HDR_LEN);
    add_payload(1);
    send_archive();
    fill_header(2, HDR_LEN + 1, 1); // plaintext one above the ratio limit (ratio 1, slack 0)
    add_header(HDR_LEN);
    add_payload(1);
    send_archive();
  endtask

  task automatic random_phase(int unsigned nbytes);
    int unsigned stop_at, r;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      repeat ($urandom_range(1, 2)) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          add_good_member();
        end else if (r < 95) begin
          add_good_member(); // one of the last 41 bytes so far overwritten, header or payload
          arc[arc.size() - 1 - $urandom_range(0, 40) % arc.size()] = 8'($urandom);
        end else begin
          add_payload($urandom_range(1, 60));
        end
      end
      r = $urandom_range(0, 9);
      if (r == 0) arc = arc[0:$urandom_range(0, arc.size() - 1)];
      else if (r == 1) add_payload($urandom_range(1, 45));
      send_archive();
    end
  endtask

  task automatic test_random_archives();
    random_phase(1);
    set_limits(LEN_CAP, 1024, 65535, 65536);
    receiver_stalls = 0;
    random_phase(1);
    receiver_stalls = 1;
    wait_idle(); // sender holds until all results are out
    set_limits(HDR_LEN + 1, 1, 0, 2);
    random_phase(1);
    set_limits($urandom_range(HDR_LEN + 20, 400), $urandom_range(1, 1023),
               $urandom_range(0, 65535), $urandom_range(1, 3));
    sender_gaps = 0;
    random_phase(1);
    sender_gaps = 1;
    set_limits(LEN_CAP, 64, 4096, 65536);
    random_phase(1);
  endtask

  // result checker and pop driver
  int unsigned pop_hold;
  always @(posedge clk_i) begin
    out_t got, want;
    if (rst_ni && pop && !empty) begin
      got = '{record_kind_o, member_index_o, header_offset_o, packed_size_o, plain_size_o,
              unix_time_o, name_length_o, archive_length_o, status_o, last_result_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (receiver_stalls) pop_hold = gap_len();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    clear_walker();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_checks();
    test_name_field();
    test_truncation();
    test_member_count();
    set_limits(LEN_CAP, 64, 4096, 65536);
    test_random_archives();
    wait_idle();
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
